// ----- design/geed_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geed_pkg
// Shared constants, types and state encoding for the gait extremum event
// detector.
// ----------------------------------------------------------------------------
package geed_pkg;

    localparam int WINDOW_LEN    = 32;
    localparam int CENTRE_INDEX  = 16;
    localparam int HISTORY_DEPTH = 3;

    // centre falls back to the newest slot when it lies outside the window
    localparam int CENTRE_POS = (CENTRE_INDEX < WINDOW_LEN) ? CENTRE_INDEX : (WINDOW_LEN - 1);

    localparam int IDX_W    = $clog2(WINDOW_LEN);
    localparam int CNT_W    = $clog2(WINDOW_LEN + 1);
    localparam int SAMPLE_W = 16;
    localparam int THR_W    = 6;
    localparam int CMP_W    = (CNT_W > THR_W) ? CNT_W : THR_W;
    localparam int TIME_W   = 32;
    localparam int PERIOD_W = TIME_W - 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(8);

    localparam int IN_TDATA_W  = 2 * SAMPLE_W;
    localparam int OUT_BITS    = 2 + TIME_W + PERIOD_W;
    localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_BITS;

    typedef logic signed [SAMPLE_W-1:0] sample_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CENTRE,
        ST_LOAD,
        ST_SCAN,
        ST_DONE
    } geed_state_t;

    typedef struct packed {
        logic clear;
        logic en;
        logic upper;
    } tally_ctl_t;

    typedef struct packed {
        logic valley;
        logic peak;
    } event_t;

endpackage

// ----- design/geed_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geed_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module geed_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/geed_tally.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geed_tally
// Shared compare unit: one window word per cycle against the centre angle,
// with per-half tallies and the event decision against the threshold.
// ----------------------------------------------------------------------------
module geed_tally (
    input  logic                      aclk,
    input  geed_pkg::tally_ctl_t      ctl,
    input  geed_pkg::sample_t         angle,
    input  geed_pkg::sample_t         velocity,
    input  geed_pkg::sample_t         centre,
    input  logic [geed_pkg::THR_W-1:0] threshold,
    output geed_pkg::event_t          events
);

    logic [geed_pkg::CNT_W-1:0] lo_reg  [2];
    logic [geed_pkg::CNT_W-1:0] hi_reg  [2];
    logic [geed_pkg::CNT_W-1:0] neg_reg [2];
    logic [geed_pkg::CNT_W-1:0] pos_reg [2];

    logic is_lo, is_hi, is_neg, is_pos;
    logic [geed_pkg::CMP_W-1:0] thr;

    assign is_lo  = angle < centre;
    assign is_hi  = angle > centre;
    assign is_neg = velocity[geed_pkg::SAMPLE_W-1];
    assign is_pos = !is_neg && (velocity != '0);

    always_ff @(posedge aclk) begin
        if (ctl.clear) begin
            for (int h = 0; h < 2; h++) begin
                lo_reg[h]  <= '0;
                hi_reg[h]  <= '0;
                neg_reg[h] <= '0;
                pos_reg[h] <= '0;
            end
        end else if (ctl.en) begin
            if (is_lo) begin
                lo_reg[ctl.upper] <= lo_reg[ctl.upper] + 1'b1;
            end
            if (is_hi) begin
                hi_reg[ctl.upper] <= hi_reg[ctl.upper] + 1'b1;
            end
            if (is_neg) begin
                neg_reg[ctl.upper] <= neg_reg[ctl.upper] + 1'b1;
            end
            if (is_pos) begin
                pos_reg[ctl.upper] <= pos_reg[ctl.upper] + 1'b1;
            end
        end
    end

    assign thr = geed_pkg::CMP_W'(threshold);

    always_comb begin
        events.valley = (geed_pkg::CMP_W'(hi_reg[0])  > thr) &&
                        (geed_pkg::CMP_W'(hi_reg[1])  > thr) &&
                        (geed_pkg::CMP_W'(neg_reg[0]) > thr) &&
                        (geed_pkg::CMP_W'(pos_reg[1]) > thr);
        events.peak   = (geed_pkg::CMP_W'(lo_reg[0])  > thr) &&
                        (geed_pkg::CMP_W'(lo_reg[1])  > thr) &&
                        (geed_pkg::CMP_W'(pos_reg[0]) > thr) &&
                        (geed_pkg::CMP_W'(neg_reg[1]) > thr);
    end

endmodule

// ----- design/geed_hist.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// geed_hist
// Valley time history and the halved span that gives the gait period.
// ----------------------------------------------------------------------------
module geed_hist (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          push,
    input  logic [geed_pkg::TIME_W-1:0]   push_time,
    output logic [geed_pkg::PERIOD_W-1:0] period_next
);

    logic [geed_pkg::TIME_W-1:0] times_reg  [geed_pkg::HISTORY_DEPTH];
    logic [geed_pkg::TIME_W-1:0] times_next [geed_pkg::HISTORY_DEPTH];
    logic [geed_pkg::TIME_W-1:0] span;

    always_comb begin
        for (int i = 0; i < geed_pkg::HISTORY_DEPTH; i++) begin
            times_next[i] = times_reg[i];
        end
        if (push) begin
            for (int i = 0; i < geed_pkg::HISTORY_DEPTH - 1; i++) begin
                times_next[i] = times_reg[i + 1];
            end
            times_next[geed_pkg::HISTORY_DEPTH - 1] = push_time;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < geed_pkg::HISTORY_DEPTH; i++) begin
                times_reg[i] <= '0;
            end
        end else begin
            for (int i = 0; i < geed_pkg::HISTORY_DEPTH; i++) begin
                times_reg[i] <= times_next[i];
            end
        end
    end

    // period reflects the history including this word's push
    assign span        = times_next[geed_pkg::HISTORY_DEPTH - 1] - times_next[0];
    assign period_next = span[geed_pkg::TIME_W-1:1];

endmodule

// ----- design/gait_extremum_event_detector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gait_extremum_event_detector_unit
// Sliding-window valley and peak detector for joint angle and velocity.
//
// Usage:
//   s_ channel takes one word per tick: angle in bits 15:0, velocity in 31:16.
//   m_ channel returns one word per input: valley flag, peak flag, centre
//   time and gait period.
//   cfg_wr_en/cfg_wr_data write the 6-bit count threshold; write only while
//   the block is idle.
//   Each word goes through these steps from acceptance to result: a centre read,
//   a step that latches the centre and clears the tallies, one RAM read per window
//   slot through a single compare and tally unit, and a decision step.
//   The single RAM read port serialises the walk; s_tready is low during the
//   walk and is high again as the result appears, so no new word is taken until the last is through.
//   The result sits in an output register, so a new word is accepted while
//   the previous result waits; if the receiver still stalls when the next
//   result is ready, the block holds it and stays not ready.
//   Reset (aresetn low, synchronous) clears the window to zeros through
//   per-slot valid bits, clears the tick count and valley history and sets
//   the threshold to 8. No clearing pass is needed.
// ----------------------------------------------------------------------------
module gait_extremum_event_detector_unit (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // angle_sample, velocity_sample
    input  logic [geed_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // valley_seen, peak_seen, centre_time, stride_period, zero pad
    output logic [geed_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                                cfg_wr_en,
    input  logic [geed_pkg::THR_W-1:0]          cfg_wr_data
);

    localparam logic [geed_pkg::IDX_W-1:0] LAST_IDX   = geed_pkg::IDX_W'(geed_pkg::WINDOW_LEN - 1);
    localparam logic [geed_pkg::IDX_W-1:0] CENTRE_IDX = geed_pkg::IDX_W'(geed_pkg::CENTRE_POS);
    localparam logic [geed_pkg::IDX_W:0]   WIN_EXT    = (geed_pkg::IDX_W+1)'(geed_pkg::WINDOW_LEN);

    geed_pkg::geed_state_t state_reg, state_next;

    logic [geed_pkg::IDX_W-1:0]      wr_ptr_reg;
    logic [geed_pkg::IDX_W-1:0]      cmp_idx_reg;
    logic [geed_pkg::WINDOW_LEN-1:0] valid_reg;
    logic                            rd_valid_reg;
    geed_pkg::sample_t               centre_reg;
    logic [geed_pkg::TIME_W-1:0]     tick_reg;
    logic [geed_pkg::THR_W-1:0]      threshold_reg;

    logic                            m_tvalid_reg;
    logic                            valley_reg;
    logic                            peak_reg;
    logic [geed_pkg::TIME_W-1:0]     ctime_reg;
    logic [geed_pkg::PERIOD_W-1:0]   period_reg;

    logic                            accept;
    logic                            done_fire;
    logic [geed_pkg::IDX_W-1:0]      rd_idx;
    logic [geed_pkg::IDX_W:0]        rd_sum;
    logic [geed_pkg::IDX_W-1:0]      rd_addr;
    logic [geed_pkg::IN_TDATA_W-1:0] ram_rdata;
    logic [geed_pkg::IN_TDATA_W-1:0] word;
    geed_pkg::tally_ctl_t            tally_ctl;
    geed_pkg::event_t                events;
    logic [geed_pkg::TIME_W-1:0]     ctime;
    logic [geed_pkg::PERIOD_W-1:0]   period_next;

    assign accept    = s_tvalid && s_tready;
    assign done_fire = (state_reg == geed_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
    assign ctime     = tick_reg - geed_pkg::TIME_W'(geed_pkg::CENTRE_INDEX);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            geed_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = geed_pkg::ST_CENTRE;
                end
            end
            geed_pkg::ST_CENTRE: begin
                state_next = geed_pkg::ST_LOAD;
            end
            geed_pkg::ST_LOAD: begin
                state_next = geed_pkg::ST_SCAN;
            end
            geed_pkg::ST_SCAN: begin
                if (cmp_idx_reg == LAST_IDX) begin
                    state_next = geed_pkg::ST_DONE;
                end
            end
            geed_pkg::ST_DONE: begin
                if (done_fire) begin
                    state_next = geed_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = geed_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        s_tready        = 1'b0;
        rd_idx          = '0;
        tally_ctl.clear = 1'b0;
        tally_ctl.en    = 1'b0;
        tally_ctl.upper = (cmp_idx_reg >= CENTRE_IDX);
        case (state_reg)
            geed_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            geed_pkg::ST_CENTRE: begin
                rd_idx = CENTRE_IDX;
            end
            geed_pkg::ST_LOAD: begin
                tally_ctl.clear = 1'b1;
            end
            geed_pkg::ST_SCAN: begin
                tally_ctl.en = 1'b1;
                rd_idx       = (cmp_idx_reg == LAST_IDX) ? '0 : (cmp_idx_reg + 1'b1);
            end
            geed_pkg::ST_DONE: begin
                rd_idx = '0;
            end
            default: begin
                rd_idx = '0;
            end
        endcase
    end

    // window slot i lives at wr_ptr + 1 + i, wrapped
    assign rd_sum  = {1'b0, wr_ptr_reg} + {1'b0, rd_idx} + 1'b1;
    assign rd_addr = (rd_sum >= WIN_EXT) ? geed_pkg::IDX_W'(rd_sum - WIN_EXT)
                                         : rd_sum[geed_pkg::IDX_W-1:0];

    // slots never written read as zero
    assign word = rd_valid_reg ? ram_rdata : '0;

    geed_ram #(
        .WIDTH (geed_pkg::IN_TDATA_W),
        .DEPTH (geed_pkg::WINDOW_LEN)
    ) u_window (
        .aclk  (aclk),
        .we    (accept),
        .waddr (wr_ptr_reg),
        .wdata (s_tdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    geed_tally u_tally (
        .aclk      (aclk),
        .ctl       (tally_ctl),
        .angle     (word[geed_pkg::SAMPLE_W-1:0]),
        .velocity  (word[2*geed_pkg::SAMPLE_W-1:geed_pkg::SAMPLE_W]),
        .centre    (centre_reg),
        .threshold (threshold_reg),
        .events    (events)
    );

    geed_hist u_hist (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .push        (done_fire && events.valley),
        .push_time   (ctime),
        .period_next (period_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= geed_pkg::ST_IDLE;
            wr_ptr_reg    <= '0;
            valid_reg     <= '0;
            tick_reg      <= '0;
            threshold_reg <= geed_pkg::THR_RESET;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                threshold_reg <= cfg_wr_data;
            end
            if (accept) begin
                valid_reg[wr_ptr_reg] <= 1'b1;
            end
            if (done_fire) begin
                wr_ptr_reg   <= (wr_ptr_reg == LAST_IDX) ? '0 : (wr_ptr_reg + 1'b1);
                tick_reg     <= tick_reg + 1'b1;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        rd_valid_reg <= valid_reg[rd_addr];
        if (state_reg == geed_pkg::ST_LOAD) begin
            centre_reg <= word[geed_pkg::SAMPLE_W-1:0];
            cmp_idx_reg <= '0;
        end else if (state_reg == geed_pkg::ST_SCAN) begin
            cmp_idx_reg <= cmp_idx_reg + 1'b1;
        end
        if (done_fire) begin
            valley_reg <= events.valley;
            peak_reg   <= events.peak;
            ctime_reg  <= ctime;
            period_reg <= period_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{geed_pkg::OUT_PAD_W{1'b0}}, period_reg, ctime_reg, peak_reg, valley_reg};

    // a word starts a full walk, so the port closes right after accepting
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("accepted a word without starting the window walk");

    // a new result only comes out of the decision step
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !$past(m_tvalid)) |-> ($past(state_reg) == geed_pkg::ST_DONE))
        else $error("result appeared outside the decision step");

    // the tick advances by exactly one per result
    assert property (@(posedge aclk) disable iff (!aresetn)
        done_fire |=> (tick_reg == $past(tick_reg) + 1'b1))
        else $error("tick count did not advance with the result");

    // a pending result is never overwritten
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !done_fire)
        else $error("pending result overwritten");

endmodule
